>>> rtl/core/vef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vef_pkg
// Shared types and constants of the vertical emboss filter.
// ----------------------------------------------------------------------------
package vef_pkg;

   // Register indexes of the configuration port
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [10:0] WIDTH_RESET  = 11'd1024;
   localparam logic [15:0] HEIGHT_RESET = 16'd768;

   localparam logic [8:0] EMBOSS_OFFSET = 9'd128;
   localparam logic [7:0] PIXEL_MAX     = 8'd255;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = 2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type  px;
      logic [15:0] row;
      logic [9:0]  col;
      logic        last;
   } result_type;

   // Per-item control carried alongside the line buffer read
   typedef struct packed {
      logic [15:0] row;       // row of the incoming pixel
      logic [9:0]  col;       // low bits of its column
      logic        row_res;   // a result for the row above is due
      logic        pass;      // the pixel itself passes through (last row)
      logic        first_row; // row above is the image's first row
   } stage_ctl_type;

endpackage

>>> rtl/core/vef_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vef_line_buf
// Two line memories (row r-2 and row r-1) with registered synchronous read
// and forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
module vef_line_buf #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  vef_pkg::pixel_type    wr_older,
   input  vef_pkg::pixel_type    wr_newer,
   output vef_pkg::pixel_type    older_q,
   output vef_pkg::pixel_type    newer_q
);
   import vef_pkg::*;

   pixel_type older_mem [DEPTH];
   pixel_type newer_mem [DEPTH];

   pixel_type older_rd_ff;
   pixel_type newer_rd_ff;
   pixel_type byp_older_ff;
   pixel_type byp_newer_ff;
   logic      byp_ff;
   logic      byp_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         newer_mem[wr_addr] <= wr_newer;
      end
      if (rd_en) begin
         older_rd_ff  <= older_mem[rd_addr];
         newer_rd_ff  <= newer_mem[rd_addr];
         byp_older_ff <= wr_older;
         byp_newer_ff <= wr_newer;
      end
   end

   // Memory reads old data on a same-edge write; take the written value then
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

   assign older_q = byp_ff ? byp_older_ff : older_rd_ff;
   assign newer_q = byp_ff ? byp_newer_ff : newer_rd_ff;

endmodule

>>> rtl/core/vef_emboss.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vef_emboss
// Row result: the stored pixel for the first row, else the clamped vertical
// difference plus 128 with saturation.
// ----------------------------------------------------------------------------
module vef_emboss (
   input  vef_pkg::pixel_type cur_px,
   input  vef_pkg::pixel_type older_px,
   input  vef_pkg::pixel_type newer_px,
   input  logic               first_row,
   output vef_pkg::pixel_type res_px
);
   import vef_pkg::*;

   logic [8:0] diff_r, diff_g, diff_b;
   logic       any_neg;
   pixel_type  emb_px;

   function automatic logic [7:0] sat_offset(input logic [7:0] d);
      logic [8:0] s;
      s = {1'b0, d} + EMBOSS_OFFSET;
      return s[8] ? PIXEL_MAX : s[7:0];
   endfunction

   assign diff_r  = {1'b0, cur_px.red}   - {1'b0, older_px.red};
   assign diff_g  = {1'b0, cur_px.green} - {1'b0, older_px.green};
   assign diff_b  = {1'b0, cur_px.blue}  - {1'b0, older_px.blue};
   assign any_neg = diff_r[8] | diff_g[8] | diff_b[8];

   always_comb begin
      if (any_neg) begin
         emb_px.red   = sat_offset(8'd0);
         emb_px.green = sat_offset(8'd0);
         emb_px.blue  = sat_offset(8'd0);
      end else begin
         emb_px.red   = sat_offset(diff_r[7:0]);
         emb_px.green = sat_offset(diff_g[7:0]);
         emb_px.blue  = sat_offset(diff_b[7:0]);
      end
   end

   assign res_px = first_row ? newer_px : emb_px;

endmodule

>>> rtl/core/vef_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vef_rsp_fifo
// Small result queue: takes up to two items per cycle, gives one.
// ----------------------------------------------------------------------------
module vef_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_cnt,
   input  vef_pkg::result_type push0,
   input  vef_pkg::result_type push1,
   output logic                space,
   output logic                pop_valid,
   input  logic                pop_ready,
   output vef_pkg::result_type pop_data
);
   import vef_pkg::*;

   result_type           mem [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]   cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0] wr_ptr_nxt;
   logic                 pop;

   assign pop        = pop_valid && pop_ready;
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign space      = (cnt_ff <= (RSP_PTR_W + 1)'(RSP_FIFO_DEPTH - 2));
   assign wr_ptr_nxt = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (RSP_PTR_W + 1)'(push_cnt) - (RSP_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem[wr_ptr_nxt] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (RSP_PTR_W + 1)'(RSP_FIFO_DEPTH))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |->
         ((cnt_ff + (RSP_PTR_W + 1)'(push_cnt)) <= (RSP_PTR_W + 1)'(RSP_FIFO_DEPTH)))
      else $error("result queue overflow");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/vertical_emboss_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_emboss_filter
// Vertical emboss of an RGB raster stream using two line memories.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle in raster order while the result queue has
// space. For an inner row the result is (row below - row above) per channel,
// all zero if any channel is negative, plus 128 saturating at 255; first and
// last rows pass through. Results lag input by one row, so each carries its
// row and column. Pixels of the last row give two results (row above and the
// pixel itself), which the result queue drains at one per cycle while the
// output accepts; otherwise sustained rate is one item per cycle, set by the
// single read-modify-write of the line memories per pixel. No clearing pass:
// line memory contents are meaningful only once a row has been written.
module vertical_emboss_filter #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // config write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   // pixel in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   // result out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // red_out, green_out, blue_out, out_row, out_col, zero pad
   output logic        rsp_tlast    // run_last
);
   import vef_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [10:0]      width_ff;
   logic [15:0]      height_ff;
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [15:0]      row_count_ff, row_count_in;

   logic [15:0]   w_eff, h_eff, h_last, col_ext;
   logic [16:0]   row_inc;
   logic          accept;
   pixel_type     in_px;

   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_addr_ff;
   pixel_type        s1_px_ff;
   stage_ctl_type    s1_ctl_ff, s1_ctl_in;
   logic             s1_fire;

   pixel_type  older_q, newer_q, row_px;
   logic       fifo_space;
   logic [1:0] push_cnt;
   result_type res_row, res_pass, push0, push1, out_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            width_ff <= csr_data[10:0];
         end
         if (csr_index == REG_IMAGE_HEIGHT) begin
            height_ff <= csr_data;
         end
      end
   end

   // Effective limits: zero treated as one, width capped at the buffer depth
   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = 16'd1;
      end else if (16'(width_ff) > 16'(MAX_WIDTH)) begin
         w_eff = 16'(MAX_WIDTH);
      end else begin
         w_eff = 16'(width_ff);
      end
      h_eff   = (height_ff == 16'd0) ? 16'd1 : height_ff;
      h_last  = h_eff - 16'd1;
      col_ext = 16'(col_count_ff);
      row_inc = {1'b0, row_count_ff} + 17'd1;
   end

   assign in_px  = pixel_type'({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]});
   assign accept = req_tvalid && req_tready;

   always_comb begin
      if ((col_ext + 16'd1) >= w_eff) begin
         col_count_in = '0;
         row_count_in = (row_inc >= {1'b0, h_eff}) ? 16'd0 : row_inc[15:0];
      end else begin
         col_count_in = col_count_ff + COL_W'(1);
         row_count_in = row_count_ff;
      end
      s1_ctl_in.row       = row_count_ff;
      s1_ctl_in.col       = col_ext[9:0];
      s1_ctl_in.row_res   = (row_count_ff != 16'd0) && (row_count_ff <= h_last);
      s1_ctl_in.pass      = (row_count_ff >= h_last);
      s1_ctl_in.first_row = (row_count_ff == 16'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // Stage 1: line memory data arrives, results formed, memory written back
   assign s1_fire    = s1_valid_ff && fifo_space;
   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= col_count_ff;
         s1_px_ff   <= in_px;
         s1_ctl_ff  <= s1_ctl_in;
      end
   end

   vef_line_buf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (col_count_ff),
      .wr_en    (s1_fire),
      .wr_addr  (s1_addr_ff),
      .wr_older (newer_q),
      .wr_newer (s1_px_ff),
      .older_q  (older_q),
      .newer_q  (newer_q)
   );

   vef_emboss u_emboss (
      .cur_px    (s1_px_ff),
      .older_px  (older_q),
      .newer_px  (newer_q),
      .first_row (s1_ctl_ff.first_row),
      .res_px    (row_px)
   );

   always_comb begin
      res_row.px    = row_px;
      res_row.row   = s1_ctl_ff.row - 16'd1;
      res_row.col   = s1_ctl_ff.col;
      res_row.last  = !s1_ctl_ff.pass;
      res_pass.px   = s1_px_ff;
      res_pass.row  = s1_ctl_ff.row;
      res_pass.col  = s1_ctl_ff.col;
      res_pass.last = 1'b1;
      push0         = s1_ctl_ff.row_res ? res_row : res_pass;
      push1         = res_pass;
      if (s1_fire) begin
         push_cnt = 2'(s1_ctl_ff.row_res) + 2'(s1_ctl_ff.pass);
      end else begin
         push_cnt = 2'd0;
      end
   end

   vef_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (push0),
      .push1     (push1),
      .space     (fifo_space),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (out_res)
   );

   assign rsp_tdata = {6'd0, out_res.col, out_res.row,
                       out_res.px.blue, out_res.px.green, out_res.px.red};
   assign rsp_tlast = out_res.last;

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff && (s1_addr_ff == $past(col_count_ff)))
      else $error("accepted item did not enter stage 1");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> s1_valid_ff && $stable(s1_addr_ff) && $stable(s1_px_ff))
      else $error("stalled stage 1 item changed");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ext < 16'(MAX_WIDTH))
      else $error("column count past buffer depth");
`endif

endmodule
